// File: rtl/temperature_trend_tracker_defines.svh
// Assertion macros of the temperature trend tracker RTL, used by its controller.
`ifndef TEMPERATURE_TREND_TRACKER_DEFINES_SVH
`define TEMPERATURE_TREND_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define TTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define TTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ttt_pkg.sv
// Types, widths and constants of the temperature trend tracker.
`default_nettype none

package ttt_pkg;

  // Window depth and the widths that follow from it
  localparam int unsigned WINDOW   = 10;
  localparam int unsigned WINDOW_W = $clog2(WINDOW);
  localparam int unsigned FILL_W   = $clog2(WINDOW + 1);

  // Field widths
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned DIFF_W   = TEMP_W + 1;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned AVG_W    = 12;
  localparam int unsigned GRAD_W   = 20;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SMALL_W  = 8;

  // Accumulator and divider widths
  localparam int unsigned SUM_W     = TEMP_W + $clog2(WINDOW);
  localparam int unsigned DSUM_W    = DIFF_W + $clog2(WINDOW);
  localparam int unsigned PROD_W    = DSUM_W + 7;
  localparam int unsigned DIV_W     = PROD_W;
  localparam int unsigned DIV_STEPS = (DIV_W + 1) / 2;
  localparam int unsigned DIV_PAD   = 2 * DIV_STEPS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int unsigned RAM_W     = DIFF_W + TEMP_W;

  localparam logic signed [PROD_W-1:0] GRAD_SCALE = PROD_W'(100);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TEMP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RESTART  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RESTART = 2'd2;

  localparam logic [SMALL_W-1:0]       SMALL_LIMIT_RESET  = 8'd5;
  localparam logic signed [TEMP_W-1:0] LOW_RESTART_RESET  = 12'sd1500;
  localparam logic signed [TEMP_W-1:0] HIGH_RESTART_RESET = -12'sd500;

  localparam logic TREND_FALL = 1'b0;
  localparam logic TREND_RISE = 1'b1;

  // Stream widths
  localparam int unsigned IN_TDATA_W = ((TEMP_W + TICK_W + 7) / 8) * 8;

  typedef enum logic {
    DIV_AVG,
    DIV_GRAD
  } ttt_div_sel_e;

  typedef struct packed {
    logic         accept;
    logic         rd_issue;
    logic         mul;
    logic         div_start;
    ttt_div_sel_e div_sel;
    logic         trend_eval;
    logic         out_load;
  } ttt_cmd_t;

  typedef struct packed {
    logic rd_last;
    logic div_busy;
    logic div_done;
  } ttt_sts_t;

  // First field in the highest bits
  typedef struct packed {
    logic [COUNT_W-1:0] small_count;
    logic [COUNT_W-1:0] rising_count;
    logic [COUNT_W-1:0] falling_count;
    logic [TEMP_W-1:0]  highest_in_up;
    logic [TEMP_W-1:0]  lowest_in_down;
    logic [TICK_W-1:0]  last_trend_ticks;
    logic               trend_changed;
    logic               trend_now;
    logic [GRAD_W-1:0]  gradient_x100;
    logic [AVG_W-1:0]   window_average;
  } ttt_result_t;

  localparam int unsigned RESULT_W    = $bits(ttt_result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: rtl/ttt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ttt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/ttt_divider.sv
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
`default_nettype none

module ttt_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ttt_pkg::DIV_W-1:0]  dividend_i,
  input  logic [ttt_pkg::FILL_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ttt_pkg::DIV_W-1:0]  quotient_o
);

  logic                         busy_q, done_q;
  logic [ttt_pkg::STEP_W-1:0]   cnt_q;
  logic [ttt_pkg::FILL_W-1:0]   divisor_q;
  logic [ttt_pkg::FILL_W:0]     rem_q, rem_d;
  logic [ttt_pkg::DIV_PAD-1:0]  quo_q, quo_d;

  logic [ttt_pkg::FILL_W:0] div_ext, rem_a, rem_a_sub, rem_b, rem_b_sub;
  logic                     bit_a, bit_b;

  // Dividend bits shift out the top of quo_q while quotient bits enter below
  assign div_ext   = {1'b0, divisor_q};
  assign rem_a     = {rem_q[ttt_pkg::FILL_W-1:0], quo_q[ttt_pkg::DIV_PAD-1]};
  assign bit_a     = (rem_a >= div_ext);
  assign rem_a_sub = bit_a ? (rem_a - div_ext) : rem_a;
  assign rem_b     = {rem_a_sub[ttt_pkg::FILL_W-1:0], quo_q[ttt_pkg::DIV_PAD-2]};
  assign bit_b     = (rem_b >= div_ext);
  assign rem_b_sub = bit_b ? (rem_b - div_ext) : rem_b;
  assign rem_d     = rem_b_sub;
  assign quo_d     = {quo_q[ttt_pkg::DIV_PAD-3:0], bit_a, bit_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ttt_pkg::STEP_W'(ttt_pkg::DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - ttt_pkg::STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= ttt_pkg::DIV_PAD'(dividend_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q[ttt_pkg::DIV_W-1:0];

endmodule

`default_nettype wire

// File: rtl/ttt_datapath.sv
// Datapath: window store, accumulators, divider, trend state and result register.
`default_nettype none

module ttt_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ttt_pkg::ttt_cmd_t                 cmd_i,
  output ttt_pkg::ttt_sts_t                 sts_o,
  input  logic signed [ttt_pkg::TEMP_W-1:0] temperature_i,
  input  logic [ttt_pkg::TICK_W-1:0]        tick_now_i,
  input  logic                              cfg_we_i,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ttt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output ttt_pkg::ttt_result_t              result_o
);

  // Configuration
  logic [ttt_pkg::SMALL_W-1:0]       small_limit_q;
  logic signed [ttt_pkg::TEMP_W-1:0] low_restart_q, high_restart_q;

  // Item and window bookkeeping
  logic signed [ttt_pkg::TEMP_W-1:0] temp_q, prev_q;
  logic [ttt_pkg::TICK_W-1:0]        tick_q;
  logic [ttt_pkg::WINDOW_W-1:0]      slot_q, rd_idx_q;
  logic [ttt_pkg::FILL_W-1:0]        fill_q;
  logic                              rd_pend_q;

  // Accumulators
  logic signed [ttt_pkg::SUM_W-1:0]  sum_q;
  logic signed [ttt_pkg::DSUM_W-1:0] dsum_q;
  logic signed [ttt_pkg::PROD_W-1:0] prod_q;
  logic [ttt_pkg::COUNT_W-1:0]       falls_q, rises_q, smalls_q;

  // Quotients
  logic                       div_neg_q;
  ttt_pkg::ttt_div_sel_e      div_sel_q;
  logic [ttt_pkg::AVG_W-1:0]  avg_q;
  logic [ttt_pkg::GRAD_W-1:0] grad_q;

  // Trend state
  logic                              trend_q, changed_q;
  logic [ttt_pkg::TICK_W-1:0]        start_tick_q, duration_q;
  logic signed [ttt_pkg::TEMP_W-1:0] lowest_q, highest_q;

  ttt_pkg::ttt_result_t result_q;

  // Window store
  logic signed [ttt_pkg::DIFF_W-1:0] diff_in;
  logic [ttt_pkg::RAM_W-1:0]         rd_data;
  logic signed [ttt_pkg::TEMP_W-1:0] rd_temp;
  logic signed [ttt_pkg::DIFF_W-1:0] rd_diff;
  logic [ttt_pkg::DIFF_W-1:0]        rd_mag;

  assign diff_in = ttt_pkg::DIFF_W'(temperature_i) - ttt_pkg::DIFF_W'(prev_q);

  ttt_ram #(
    .WIDTH (ttt_pkg::RAM_W),
    .DEPTH (ttt_pkg::WINDOW)
  ) u_window (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.accept),
    .wr_addr_i (slot_q),
    .wr_data_i ({diff_in, temperature_i}),
    .rd_en_i   (cmd_i.rd_issue),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  assign rd_temp = rd_data[ttt_pkg::TEMP_W-1:0];
  assign rd_diff = rd_data[ttt_pkg::RAM_W-1:ttt_pkg::TEMP_W];
  assign rd_mag  = rd_diff[ttt_pkg::DIFF_W-1] ? ttt_pkg::DIFF_W'(-rd_diff)
                                              : ttt_pkg::DIFF_W'(rd_diff);

  // Divider operands: magnitudes, sign restored on the quotient
  logic                       sum_neg, prod_neg;
  logic [ttt_pkg::SUM_W-1:0]  sum_abs;
  logic [ttt_pkg::PROD_W-1:0] prod_abs;
  logic [ttt_pkg::DIV_W-1:0]  dividend, quotient, quot_fix;
  logic                       div_busy, div_done;

  assign sum_neg  = sum_q[ttt_pkg::SUM_W-1];
  assign prod_neg = prod_q[ttt_pkg::PROD_W-1];
  assign sum_abs  = sum_neg ? ttt_pkg::SUM_W'(-sum_q) : ttt_pkg::SUM_W'(sum_q);
  assign prod_abs = prod_neg ? ttt_pkg::PROD_W'(-prod_q) : ttt_pkg::PROD_W'(prod_q);
  assign dividend = (cmd_i.div_sel == ttt_pkg::DIV_AVG) ? ttt_pkg::DIV_W'(sum_abs)
                                                        : ttt_pkg::DIV_W'(prod_abs);
  assign quot_fix = div_neg_q ? (ttt_pkg::DIV_W'(0) - quotient) : quotient;

  ttt_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Trend classification of the finished window
  logic down_win, up_win;
  assign down_win = (falls_q != '0) && (rises_q == '0);
  assign up_win   = (rises_q != '0) && (falls_q == '0);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_limit_q  <= ttt_pkg::SMALL_LIMIT_RESET;
      low_restart_q  <= ttt_pkg::LOW_RESTART_RESET;
      high_restart_q <= ttt_pkg::HIGH_RESTART_RESET;
      prev_q         <= '0;
      slot_q         <= '0;
      fill_q         <= '0;
      rd_idx_q       <= '0;
      rd_pend_q      <= 1'b0;
      trend_q        <= ttt_pkg::TREND_FALL;
      changed_q      <= 1'b0;
      start_tick_q   <= '0;
      duration_q     <= '0;
      lowest_q       <= ttt_pkg::LOW_RESTART_RESET;
      highest_q      <= ttt_pkg::HIGH_RESTART_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ttt_pkg::CFG_SMALL_LIMIT:  small_limit_q  <= cfg_data_i[ttt_pkg::SMALL_W-1:0];
          ttt_pkg::CFG_LOW_RESTART:  low_restart_q  <= cfg_data_i[ttt_pkg::TEMP_W-1:0];
          ttt_pkg::CFG_HIGH_RESTART: high_restart_q <= cfg_data_i[ttt_pkg::TEMP_W-1:0];
          default: ;
        endcase
      end

      rd_pend_q <= cmd_i.rd_issue;

      if (cmd_i.accept) begin
        prev_q   <= temperature_i;
        rd_idx_q <= '0;
        slot_q   <= (slot_q == ttt_pkg::WINDOW_W'(ttt_pkg::WINDOW - 1)) ? '0
                    : slot_q + ttt_pkg::WINDOW_W'(1);
        if (fill_q != ttt_pkg::FILL_W'(ttt_pkg::WINDOW)) begin
          fill_q <= fill_q + ttt_pkg::FILL_W'(1);
        end
      end else if (cmd_i.rd_issue) begin
        rd_idx_q <= rd_idx_q + ttt_pkg::WINDOW_W'(1);
      end

      if (cmd_i.trend_eval) begin
        changed_q <= 1'b0;
        priority if (down_win) begin
          if (trend_q != ttt_pkg::TREND_FALL) begin
            duration_q   <= tick_q - start_tick_q;
            trend_q      <= ttt_pkg::TREND_FALL;
            lowest_q     <= low_restart_q;
            start_tick_q <= tick_q;
            changed_q    <= 1'b1;
          end else if (temp_q < lowest_q) begin
            lowest_q <= temp_q;
          end
        end else if (up_win) begin
          if (trend_q != ttt_pkg::TREND_RISE) begin
            duration_q   <= tick_q - start_tick_q;
            trend_q      <= ttt_pkg::TREND_RISE;
            highest_q    <= high_restart_q;
            start_tick_q <= tick_q;
            changed_q    <= 1'b1;
          end else if (temp_q > highest_q) begin
            highest_q <= temp_q;
          end
        end else begin
          // Mixed or flat window: hold trend and trackers
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      temp_q   <= temperature_i;
      tick_q   <= tick_now_i;
      sum_q    <= '0;
      dsum_q   <= '0;
      falls_q  <= '0;
      rises_q  <= '0;
      smalls_q <= '0;
    end else if (rd_pend_q) begin
      sum_q  <= sum_q + ttt_pkg::SUM_W'(rd_temp);
      dsum_q <= dsum_q + ttt_pkg::DSUM_W'(rd_diff);
      if (rd_diff[ttt_pkg::DIFF_W-1]) begin
        falls_q <= falls_q + ttt_pkg::COUNT_W'(1);
      end
      if (!rd_diff[ttt_pkg::DIFF_W-1] && (rd_diff != '0)) begin
        rises_q <= rises_q + ttt_pkg::COUNT_W'(1);
      end
      if (rd_mag < ttt_pkg::DIFF_W'(small_limit_q)) begin
        smalls_q <= smalls_q + ttt_pkg::COUNT_W'(1);
      end
    end

    if (cmd_i.mul) begin
      prod_q <= ttt_pkg::PROD_W'(dsum_q) * ttt_pkg::GRAD_SCALE;
    end

    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
      div_neg_q <= (cmd_i.div_sel == ttt_pkg::DIV_AVG) ? sum_neg : prod_neg;
    end

    if (div_done) begin
      if (div_sel_q == ttt_pkg::DIV_AVG) begin
        avg_q <= quot_fix[ttt_pkg::AVG_W-1:0];
      end else begin
        grad_q <= quot_fix[ttt_pkg::GRAD_W-1:0];
      end
    end

    if (cmd_i.out_load) begin
      result_q.window_average   <= avg_q;
      result_q.gradient_x100    <= grad_q;
      result_q.trend_now        <= trend_q;
      result_q.trend_changed    <= changed_q;
      result_q.last_trend_ticks <= duration_q;
      result_q.lowest_in_down   <= lowest_q;
      result_q.highest_in_up    <= highest_q;
      result_q.falling_count    <= falls_q;
      result_q.rising_count     <= rises_q;
      result_q.small_count      <= smalls_q;
    end
  end

  assign sts_o.rd_last  = ((ttt_pkg::FILL_W'(rd_idx_q) + ttt_pkg::FILL_W'(1)) == fill_q);
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// File: rtl/ttt_controller.sv
// Controller: sequences window walk, scaling, divisions, trend update and output beat.
`default_nettype none

`include "temperature_trend_tracker_defines.svh"

module ttt_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output ttt_pkg::ttt_cmd_t cmd_o,
  input  ttt_pkg::ttt_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MUL,
    ST_DIV_AVG,
    ST_WAIT_AVG,
    ST_DIV_GRAD,
    ST_WAIT_GRAD,
    ST_TREND,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic              out_valid_q;
  ttt_pkg::ttt_cmd_t cmd;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word lands in the accumulators
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ttt_pkg::DIV_AVG;
        state_d       = ST_WAIT_AVG;
      end
      ST_WAIT_AVG: begin
        if (sts_i.div_done) begin
          state_d = ST_DIV_GRAD;
        end
      end
      ST_DIV_GRAD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ttt_pkg::DIV_GRAD;
        state_d       = ST_WAIT_GRAD;
      end
      ST_WAIT_GRAD: begin
        if (sts_i.div_done) begin
          state_d = ST_TREND;
        end
      end
      ST_TREND: begin
        cmd.trend_eval = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o     = cmd;
  assign m_valid_o = out_valid_q;

  `TTT_ASSERT_NEXT(a_accept_then_busy, s_valid_i && s_ready_o, !s_ready_o, "ready after accept")
  `TTT_ASSERT_NOW(a_div_start_idle, cmd.div_start, !sts_i.div_busy, "divider restarted busy")
  `TTT_ASSERT_NOW(a_load_slot_free, cmd.out_load, !out_valid_q || m_ready_i, "result overwritten")
  `TTT_ASSERT_NEXT(a_load_then_valid, cmd.out_load, m_valid_o, "loaded result not shown")

endmodule

`default_nettype wire

// File: rtl/temperature_trend_tracker.sv
// Top level of the temperature trend tracker.
// Each input beat walks the filled window over the RAM read port, scales the delta sum,
// takes two passes through the 2-bit-per-cycle divider (average, then gradient) and updates
// the trend; the next input beat is taken once the result is in the output register.
// A new input beat is taken while the previous result still waits on the output register.
// Reset (rst_ni low, asynchronous) clears fill, slot, trend and trackers; no clearing pass.
`default_nettype none

module temperature_trend_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: temperature [11:0], tick_now [43:12], zero pad
  input  logic [ttt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: window_average, gradient_x100, trend_now, trend_changed, last_trend_ticks,
  //        lowest_in_down, highest_in_up, falling_count, rising_count, small_count, pad
  output logic [ttt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ttt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ttt_pkg::ttt_cmd_t    cmd;
  ttt_pkg::ttt_sts_t    sts;
  ttt_pkg::ttt_result_t result;

  assign cfg_ready_o = 1'b1;

  ttt_controller u_controller (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ttt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .temperature_i (s_axis_tdata_i[ttt_pkg::TEMP_W-1:0]),
    .tick_now_i    (s_axis_tdata_i[ttt_pkg::TEMP_W+ttt_pkg::TICK_W-1:ttt_pkg::TEMP_W]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_o      (result)
  );

  assign m_axis_tdata_o = ttt_pkg::OUT_TDATA_W'(result);

endmodule

`default_nettype wire

// File: bench/temperature_trend_tracker_test.sv
// Self-checking testbench for the temperature trend tracker: stream stimulus and result checks.
`timescale 1ns / 1ps

module temperature_trend_tracker_test;
  import ttt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int TEMP_MIN = -1000;
  localparam int TEMP_MAX = 2000;

  logic                     clk_i;
  logic                     rst_ni;
  logic [IN_TDATA_W-1:0]    s_axis_tdata_i;
  logic                     s_axis_tvalid_i;
  logic                     s_axis_tready_o;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata_o;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  // Window, trend and tracker state mirrored from accepted beats; holds the awaited reports.
  class trend_scoreboard;
    logic [SMALL_W-1:0]         small_limit;
    logic signed [TEMP_W-1:0]   low_restart;
    logic signed [TEMP_W-1:0]   high_restart;
    logic signed [TEMP_W-1:0]   sample_ring[WINDOW];
    logic signed [DIFF_W-1:0]   delta_ring[WINDOW];
    int unsigned                slot;
    int unsigned                fill;
    logic signed [TEMP_W-1:0]   prev_temp;
    logic                       trend;
    logic [TICK_W-1:0]          start_tick;
    logic [TICK_W-1:0]          duration;
    logic signed [TEMP_W-1:0]   lowest;
    logic signed [TEMP_W-1:0]   highest;
    ttt_result_t                awaited_reports[$];
    int unsigned                errors;
    int unsigned                results_seen;
    int unsigned                samples_seen;
    int unsigned                reg_writes;
    int unsigned                trend_flips;
    int unsigned                flips_up;

    function new();
      small_limit  = SMALL_LIMIT_RESET;
      low_restart  = LOW_RESTART_RESET;
      high_restart = HIGH_RESTART_RESET;
      foreach (sample_ring[i]) begin
        sample_ring[i] = '0;
        delta_ring[i]  = '0;
      end
      slot       = 0;
      fill       = 0;
      prev_temp  = '0;
      trend      = TREND_FALL;
      start_tick = '0;
      duration   = '0;
      lowest     = LOW_RESTART_RESET;
      highest    = HIGH_RESTART_RESET;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_SMALL_LIMIT:  small_limit  = data[SMALL_W-1:0];
        CFG_LOW_RESTART:  low_restart  = data;
        CFG_HIGH_RESTART: high_restart = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [TEMP_W-1:0] temp, logic [TICK_W-1:0] tick);
      int          sum;
      int          dsum;
      int          d;
      int          mag;
      int unsigned falls;
      int unsigned rises;
      int unsigned smalls;
      logic        changed;
      ttt_result_t r;
      sample_ring[slot] = temp;
      delta_ring[slot]  = DIFF_W'(int'(temp) - int'(prev_temp));
      prev_temp = temp;
      slot = (slot + 1) % WINDOW;
      if (fill < WINDOW) fill++;
      sum = 0;
      dsum = 0;
      falls = 0;
      rises = 0;
      smalls = 0;
      changed = 1'b0;
      for (int i = 0; i < int'(fill); i++) begin
        d = int'(delta_ring[i]);
        mag = (d < 0) ? -d : d;
        sum += int'(sample_ring[i]);
        dsum += d;
        if (d < 0) falls++;
        if (d > 0) rises++;
        if (mag < int'(small_limit)) smalls++;
      end
      if (falls != 0 && rises == 0) begin
        if (trend != TREND_FALL) begin
          duration   = tick - start_tick;
          trend      = TREND_FALL;
          lowest     = low_restart;
          start_tick = tick;
          changed    = 1'b1;
        end else if (temp < lowest) begin
          lowest = temp;
        end
      end else if (rises != 0 && falls == 0) begin
        if (trend != TREND_RISE) begin
          duration   = tick - start_tick;
          trend      = TREND_RISE;
          highest    = high_restart;
          start_tick = tick;
          changed    = 1'b1;
          flips_up++;
        end else if (temp > highest) begin
          highest = temp;
        end
      end
      if (changed) trend_flips++;
      r.window_average   = AVG_W'(sum / int'(fill));
      r.gradient_x100    = GRAD_W'((dsum * 100) / int'(fill));
      r.trend_now        = trend;
      r.trend_changed    = changed;
      r.last_trend_ticks = duration;
      r.lowest_in_down   = lowest;
      r.highest_in_up    = highest;
      r.falling_count    = COUNT_W'(falls);
      r.rising_count     = COUNT_W'(rises);
      r.small_count      = COUNT_W'(smalls);
      awaited_reports.push_back(r);
      samples_seen++;
    endfunction

    task report(string what);
      errors++;
      // cap the log; every mismatch still counts
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] beat);
      ttt_result_t got;
      ttt_result_t want;
      got = beat[RESULT_W-1:0];
      if (awaited_reports.size() == 0) begin
        report("result beat with no sample waiting");
        return;
      end
      want = awaited_reports.pop_front();
      compare_field("window_average", 32'(got.window_average), 32'(want.window_average));
      compare_field("gradient_x100", 32'(got.gradient_x100), 32'(want.gradient_x100));
      compare_field("trend_now", 32'(got.trend_now), 32'(want.trend_now));
      compare_field("trend_changed", 32'(got.trend_changed), 32'(want.trend_changed));
      compare_field("last_trend_ticks", got.last_trend_ticks, want.last_trend_ticks);
      compare_field("lowest_in_down", 32'(got.lowest_in_down), 32'(want.lowest_in_down));
      compare_field("highest_in_up", 32'(got.highest_in_up), 32'(want.highest_in_up));
      compare_field("falling_count", 32'(got.falling_count), 32'(want.falling_count));
      compare_field("rising_count", 32'(got.rising_count), 32'(want.rising_count));
      compare_field("small_count", 32'(got.small_count), 32'(want.small_count));
      results_seen++;
    endtask

    function int unsigned pending();
      return awaited_reports.size();
    endfunction
  endclass

  trend_scoreboard   trend_sb;
  bit                steady_run;
  int                level;
  logic [TICK_W-1:0] tick_now_q;
  int unsigned       idle_cycles;

  temperature_trend_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: ready in random stretches, broken by stalls until the steady part.
  initial begin
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!steady_run) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Sample every handshake on the edge, watch for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_valid_i && cfg_ready_o) trend_sb.note_config(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        trend_sb.note_sample(s_axis_tdata_i[TEMP_W-1:0], s_axis_tdata_i[TEMP_W +: TICK_W]);
      if (m_axis_tvalid_o && m_axis_tready_i) trend_sb.check_result(m_axis_tdata_o);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    return TEMP_W'(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
  endfunction

  // Leave tvalid high after the beat so back-to-back samples need no second assignment.
  task automatic send_sample(input logic signed [TEMP_W-1:0] temp,
                             input logic [TICK_W-1:0] tick);
    if (!steady_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {{(IN_TDATA_W - TEMP_W - TICK_W){1'b0}}, tick, temp};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (trend_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] limit_word,
                              input logic signed [TEMP_W-1:0] low_val,
                              input logic signed [TEMP_W-1:0] high_val,
                              input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx_list[4];
    logic [CFG_DATA_W-1:0] val_list[4];
    int                    n;
    n = 0;
    if (poke_unused) begin
      idx_list[n] = CFG_UNUSED;
      val_list[n] = CFG_DATA_W'($urandom);
      n++;
    end
    idx_list[n] = CFG_SMALL_LIMIT;
    val_list[n] = limit_word;
    n++;
    idx_list[n] = CFG_LOW_RESTART;
    val_list[n] = low_val;
    n++;
    idx_list[n] = CFG_HIGH_RESTART;
    val_list[n] = high_val;
    n++;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= val_list[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Runs of climbs, falls, jitter, flats and random jumps so the window settles into a trend and flips.
  task automatic run_phase(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned kind;
    int          step;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      run_len = $urandom_range(3, 24);
      for (int k = 0; k < int'(run_len) && sent < count; k++) begin
        case (kind)
          0, 1, 2: step = int'($urandom_range(0, 60));
          3, 4, 5: step = -int'($urandom_range(0, 60));
          6:       step = int'($urandom_range(0, 8)) - 4;
          7:       step = 0;
          8:       step = int'(rand_temp()) - level;
          default: step = int'($urandom_range(0, 400)) - 200;
        endcase
        level += step;
        if (level > TEMP_MAX) level = TEMP_MAX;
        if (level < TEMP_MIN) level = TEMP_MIN;
        if ($urandom_range(0, 49) == 0) tick_now_q = $urandom;
        else tick_now_q += $urandom_range(1, 5000);
        send_sample(TEMP_W'(level), tick_now_q);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    steady_run  = 1'b0;
    idle_cycles = 0;
    level       = 0;
    tick_now_q  = '0;
    trend_sb    = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: fall, rise to mixed, up trend, back down across the tick wrap.
    send_sample(12'sd0, 32'd0);
    send_sample(-12'sd1000, 32'd1);
    send_sample(-12'sd1000, 32'd2);
    send_sample(12'sd2000, 32'd3);
    for (int i = 0; i < 9; i++) send_sample(12'sd2000, 32'hFFFF_FFF0 + i);
    send_sample(-12'sd1000, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) send_sample(-12'sd1000, i);
    s_axis_tvalid_i <= 1'b0;
    level = TEMP_MIN;
    tick_now_q = 32'd8;

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase == 7) steady_run = 1'b1;
      case (phase)
        0: program_regs(12'h000, -12'sd1000, 12'sd2000, 1'b0);
        1: program_regs(12'hAFF, 12'sd2000, -12'sd1000, 1'b1);
        default: begin
          if ($urandom_range(0, 2) == 0)
            program_regs(CFG_DATA_W'($urandom), rand_temp(), rand_temp(),
                         1'($urandom_range(0, 1)));
          else
            program_regs({4'($urandom), 8'($urandom_range(0, 40))}, rand_temp(), rand_temp(),
                         1'($urandom_range(0, 1)));
        end
      endcase
      run_phase(60);
      s_axis_tvalid_i <= 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d samples, %0d results compared, %0d register writes",
             trend_sb.samples_seen, trend_sb.results_seen, trend_sb.reg_writes);
    $display("trend flips: %0d (%0d to up), mismatches: %0d",
             trend_sb.trend_flips, trend_sb.flips_up, trend_sb.errors);
    if (trend_sb.errors == 0 && trend_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      if (trend_sb.pending() != 0)
        $display("%0d results never arrived", trend_sb.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ttt_pkg.sv
rtl/ttt_ram.sv
rtl/ttt_divider.sv
rtl/ttt_datapath.sv
rtl/ttt_controller.sv
rtl/temperature_trend_tracker.sv
bench/temperature_trend_tracker_test.sv
